[design/pps_pkg.sv]
package pps_pkg;

  // job table capacity and derived widths
  localparam int unsigned MAX_JOBS = 16;
  localparam int unsigned IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CNT_W    = $clog2(MAX_JOBS + 1);

  localparam int unsigned TIME_W   = 16;
  localparam int unsigned BURST_W  = 12;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned RUN_W    = 4;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic               op;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  priority_req;
  } in_t;

  typedef struct packed {
    logic [RUN_W-1:0]  run_id;
    logic              idle;
    logic              first_run;
    logic [TIME_W-1:0] response_time;
    logic              done_res;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;
  } out_t;

  // one job table row
  typedef struct packed {
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] remaining;
  } row_t;

  // control from the sequencer to the compare unit
  typedef struct packed {
    logic             clear;
    logic             valid;
    logic [IDX_W-1:0] idx;
  } sel_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

endpackage

[design/preemptive_priority_scheduler_unit.sv]
// channel | direction | handshake                 | payload
// --------+-----------+---------------------------+-----------------------------
// in      | input     | in_valid_i / in_stall_o   | in_data_i, op and job fields
// out     | output    | out_valid_o / out_stall_i | out_data_o, one per tick
//
// a load writes the job row and produces no result
// a tick reads one slot per cycle through the single read port, then runs
// a drain step and then the result; an empty table goes straight to the result
// reset clears the counters, the started flags and the sequencer, not the rows
// any item is taken while the sequencer is idle, even with a result held;
// a tick then waits in its last step until the stalled result has left
module preemptive_priority_scheduler_unit
  import pps_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  state_e state_q, state_d;

  // scan counter and the slot whose read data is on the table output
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;

  logic [CNT_W-1:0]  job_count_q, job_count_d;
  logic [CNT_W-1:0]  fin_q, fin_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [MAX_JOBS-1:0] started_q, started_d;

  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  // job table port signals
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  row_t             wr_data;
  logic             rd_en;
  row_t             rd_data;

  // compare unit
  sel_ctl_t         sel_ctl;
  logic             found;
  logic [IDX_W-1:0] best_idx;
  row_t             best_row;

  // arithmetic on the chosen job
  logic [BURST_W-1:0] rem_new;
  logic [TIME_W-1:0]  resp;
  logic [TIME_W-1:0]  ct;
  logic [TIME_W-1:0]  ta;
  logic [TIME_W-1:0]  wt;
  logic               in_acc;
  logic               out_blocked;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_blocked = out_valid_q && out_stall_i;

  assign rem_new = best_row.remaining - BURST_W'(1);
  assign resp    = time_q - best_row.arrival;
  assign ct      = time_q + TIME_W'(1);
  assign ta      = ct - best_row.arrival;
  assign wt      = ta - TIME_W'(best_row.burst);

  pps_table u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (cnt_q),
    .rd_data_o (rd_data)
  );

  pps_sel u_sel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (sel_ctl),
    .row_i      (rd_data),
    .now_i      (time_q),
    .found_o    (found),
    .best_idx_o (best_idx),
    .best_row_o (best_row)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    job_count_d = job_count_q;
    fin_d       = fin_q;
    time_d      = time_q;
    started_d   = started_q;
    out_valid_d = out_blocked;
    out_d       = out_q;
    wr_en       = 1'b0;
    wr_addr     = best_idx;
    wr_data     = best_row;
    rd_en       = 1'b0;
    sel_ctl.clear = 1'b0;
    sel_ctl.valid = rd_vld_q;
    sel_ctl.idx   = rd_idx_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.op == OP_LOAD) begin
            // loads past capacity are dropped
            if (job_count_q < CNT_W'(MAX_JOBS)) begin
              wr_en             = 1'b1;
              wr_addr           = job_count_q[IDX_W-1:0];
              wr_data.arrival   = in_data_i.arrival;
              wr_data.burst     = in_data_i.burst;
              wr_data.prio      = in_data_i.priority_req;
              wr_data.remaining = in_data_i.burst;
              started_d[job_count_q[IDX_W-1:0]] = 1'b0;
              job_count_d = job_count_q + CNT_W'(1);
              // a zero-length job counts as finished right away
              if (in_data_i.burst == '0) begin
                fin_d = fin_q + CNT_W'(1);
              end
            end
          end else begin
            sel_ctl.clear = 1'b1;
            cnt_d         = '0;
            state_d       = (job_count_q == '0) ? ST_FINISH : ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // one slot read per cycle, compared in the cycle after
        rd_en = 1'b1;
        cnt_d = cnt_q + IDX_W'(1);
        if (CNT_W'(cnt_q) == job_count_q - CNT_W'(1)) begin
          state_d = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        // last slot is in the compare unit this cycle
        state_d = ST_FINISH;
      end

      ST_FINISH: begin
        if (!out_blocked) begin
          out_valid_d  = 1'b1;
          out_d        = '0;
          out_d.idle   = !found;
          if (found) begin
            out_d.run_id = RUN_W'(best_idx);
            if (!started_q[best_idx]) begin
              out_d.first_run     = 1'b1;
              out_d.response_time = resp;
            end
            started_d[best_idx] = 1'b1;
            // write back the decremented remaining time
            wr_en             = 1'b1;
            wr_addr           = best_idx;
            wr_data           = best_row;
            wr_data.remaining = rem_new;
            if (rem_new == '0) begin
              out_d.done_res        = 1'b1;
              out_d.completion_time = ct;
              out_d.turnaround      = ta;
              out_d.waiting         = wt;
              fin_d                 = fin_q + CNT_W'(1);
            end
          end
          out_d.all_done = (fin_d == job_count_q);
          time_d  = ct;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      job_count_q <= '0;
      fin_q       <= '0;
      time_q      <= '0;
      started_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      rd_vld_q    <= rd_en;
      job_count_q <= job_count_d;
      fin_q       <= fin_d;
      time_q      <= time_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // finished jobs never outnumber loaded ones
  a_fin_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q <= job_count_q)
    else $error("finished count exceeds job count");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_count_q <= CNT_W'(MAX_JOBS))
    else $error("job count beyond capacity");

  // a scan only runs over a non-empty table
  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (job_count_q != '0))
    else $error("scan with empty table");

  // an idle tick reports nothing about a job
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.idle) |-> (!out_q.first_run && !out_q.done_res))
    else $error("idle tick carries job flags");

  // the time advances exactly when a result is produced
  a_time_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && !out_blocked) |=> (time_q == $past(time_q) + TIME_W'(1)))
    else $error("time did not advance on tick");

endmodule

[design/pps_table.sv]
module pps_table
  import pps_pkg::*;
(
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  row_t             wr_data_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output row_t             rd_data_o
);

  row_t mem [MAX_JOBS];
  row_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/pps_sel.sv]
module pps_sel
  import pps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sel_ctl_t          ctl_i,
  input  row_t              row_i,
  input  logic [TIME_W-1:0] now_i,
  output logic              found_o,
  output logic [IDX_W-1:0]  best_idx_o,
  output row_t              best_row_o
);

  logic             found_q;
  logic [IDX_W-1:0] best_idx_q;
  row_t             best_row_q;
  logic             ready;
  logic             take;

  // arrived and not yet finished
  assign ready = (row_i.arrival <= now_i) && (row_i.remaining != '0);
  // strict compare keeps the lowest id on equal priority
  assign take  = ctl_i.valid && ready && (!found_q || (row_i.prio < best_row_q.prio));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ctl_i.clear && take) begin
      best_idx_q <= ctl_i.idx;
      best_row_q <= row_i;
    end
  end

  assign found_o    = found_q;
  assign best_idx_o = best_idx_q;
  assign best_row_o = best_row_q;

endmodule
